// File: src/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and constants of the sorted deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

  // widths of the item fields on the channels
  localparam int TIME_FIELD_W = 32;
  localparam int ID_FIELD_W   = 16;

  // most expired timers a single tick may pop
  localparam int MAX_RESULTS  = 16;
  localparam int POP_CNT_W    = $clog2(MAX_RESULTS + 1);

  // command queue between front and back
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } dtq_op_t;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_EXPIRED = 1'b1
  } dtq_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } dtq_state_t;

endpackage

// File: src/dtq_if.sv
// ----------------------------------------------------------------------------
// dtq_if
// valid/ready channels for request and result items
// ----------------------------------------------------------------------------
interface dtq_in_if
  import dtq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [TIME_FIELD_W-1:0] time_value;

  modport source (output valid, output req_type, output time_value, input ready);
  modport sink   (input valid, input req_type, input time_value, output ready);
endinterface

interface dtq_out_if
  import dtq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    result_kind;
  logic [ID_FIELD_W-1:0]   timer_id;
  logic [TIME_FIELD_W-1:0] expiry_out;
  logic                    table_full;
  logic                    last_in_run;

  modport source (output valid, output result_kind, output timer_id, output expiry_out,
                  output table_full, output last_in_run, input ready);
  modport sink   (input valid, input result_kind, input timer_id, input expiry_out,
                  input table_full, input last_in_run, output ready);
endinterface

// File: src/dtq_front.sv
// ----------------------------------------------------------------------------
// dtq_front
// accepts request items, decodes them and queues commands for the back end
// ----------------------------------------------------------------------------
module dtq_front
  import dtq_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  dtq_in_if.sink               cmd,
  output logic                 cmd_valid,
  output dtq_op_t              cmd_op,
  output logic [TIME_BITS-1:0] cmd_time,
  input  logic                 cmd_pop
);

  dtq_op_t              q_op   [QDEPTH];
  logic [TIME_BITS-1:0] q_time [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;
  logic                 push;
  logic                 pop;
  logic [TIME_BITS+TIME_FIELD_W-1:0] time_wide;

  assign time_wide = {{TIME_BITS{1'b0}}, cmd.time_value};
  assign cmd.ready = (count != QCNT_W'(QDEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign pop       = cmd_pop && cmd_valid;

  assign cmd_valid = (count != '0);
  assign cmd_op    = q_op[rd_ptr];
  assign cmd_time  = q_time[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]   <= cmd.req_type ? OP_TICK : OP_ADD;
      q_time[wr_ptr] <= time_wide[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/dtq_back.sv
// ----------------------------------------------------------------------------
// dtq_back
// sorted timer table: inserts adds, pops due timers on ticks, drives results
// ----------------------------------------------------------------------------
module dtq_back
  import dtq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  dtq_op_t              cmd_op,
  input  logic [TIME_BITS-1:0] cmd_time,
  output logic                 cmd_pop,
  dtq_out_if.source            rsp
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  // table cells, each shifts from its lower neighbor on an add and its upper one on a pop
  logic [TIME_BITS-1:0] exp_q [DEPTH];
  logic [ID_BITS-1:0]   id_q  [DEPTH];

  logic [OCC_W-1:0]     occ;
  logic [ID_BITS-1:0]   next_id;
  dtq_state_t           state;
  logic [TIME_BITS-1:0] tick_time;
  logic [POP_CNT_W-1:0] popped;

  dtq_kind_t            out_kind;
  logic [ID_BITS-1:0]   out_id;
  logic [TIME_BITS-1:0] out_exp;
  logic                 out_full;
  logic                 out_last;
  logic                 out_valid;

  logic                 adv;
  logic                 full;
  logic [DEPTH-1:0]     lt;
  logic [DEPTH-1:0]     prev_lt;
  logic                 head_due;
  logic                 next_due;
  logic [ID_BITS+ID_FIELD_W-1:0]     id_wide;
  logic [TIME_BITS+TIME_FIELD_W-1:0] exp_wide;

  assign adv  = !out_valid || rsp.ready;
  assign full = (occ == OCC_W'(DEPTH));

  // cells holding a strictly earlier expiry stay put
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (OCC_W'(i) < occ) && (exp_q[i] < cmd_time);
    end
  end
  assign prev_lt = {lt[DEPTH-2:0], 1'b1};

  assign head_due = (occ != '0) && (exp_q[0] <= tick_time);
  assign next_due = (occ > OCC_W'(1)) && (exp_q[1] <= tick_time) &&
                    ((popped + 1'b1) < POP_CNT_W'(MAX_RESULTS));

  assign cmd_pop = (state == ST_IDLE) && cmd_valid && ((cmd_op == OP_TICK) || adv);

  // table cells
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid && (cmd_op == OP_ADD) && adv && !full) begin
          for (int i = 1; i < DEPTH; i++) begin
            if (!lt[i]) begin
              exp_q[i] <= prev_lt[i] ? cmd_time : exp_q[i-1];
              id_q[i]  <= prev_lt[i] ? next_id  : id_q[i-1];
            end
          end
          if (!lt[0]) begin
            exp_q[0] <= cmd_time;
            id_q[0]  <= next_id;
          end
        end
      end
      ST_POP: begin
        if (adv && head_due) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            exp_q[i] <= exp_q[i+1];
            id_q[i]  <= id_q[i+1];
          end
        end
      end
      default: ;
    endcase
  end

  // result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid && (cmd_op == OP_ADD) && adv) begin
          out_kind <= KIND_ACK;
          out_id   <= full ? '0 : next_id;
          out_exp  <= '0;
          out_full <= full;
          out_last <= 1'b1;
        end
        if (cmd_valid && (cmd_op == OP_TICK)) begin
          tick_time <= cmd_time;
        end
      end
      ST_POP: begin
        if (adv && head_due) begin
          out_kind <= KIND_EXPIRED;
          out_id   <= id_q[0];
          out_exp  <= exp_q[0];
          out_full <= 1'b0;
          out_last <= !next_due;
        end
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      next_id   <= '0;
      popped    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid && (cmd_op == OP_ADD) && adv) begin
            out_valid <= 1'b1;
            if (!full) begin
              occ     <= occ + 1'b1;
              next_id <= next_id + 1'b1;
            end
          end
          if (cmd_valid && (cmd_op == OP_TICK)) begin
            popped <= '0;
            state  <= ST_POP;
          end
        end
        ST_POP: begin
          if (adv) begin
            if (head_due) begin
              out_valid <= 1'b1;
              occ       <= occ - 1'b1;
              popped    <= popped + 1'b1;
              if (!next_due) state <= ST_IDLE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign id_wide  = {{ID_FIELD_W{1'b0}}, out_id};
  assign exp_wide = {{TIME_FIELD_W{1'b0}}, out_exp};

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.timer_id    = id_wide[ID_FIELD_W-1:0];
  assign rsp.expiry_out  = exp_wide[TIME_FIELD_W-1:0];
  assign rsp.table_full  = out_full;
  assign rsp.last_in_run = out_last;

endmodule

// File: src/sorted_deadline_timer_queue_unit.sv
// path: an add answer leaves the output register after the front queue; a tick's first
//   expired timer follows the front queue and the pop state, then one more each cycle
//   while results are taken; the table engine takes a new add as its last answer is
//   taken; a tick holds later commands while it pops up to 16 due timers, one a cycle
// reset: synchronous rst empties the table and the command queue, zeroes the
//   identifier counter and drops any pending result; no clearing pass
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_unit
// fixed-depth one-shot timer table kept sorted by expiry time
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_unit
  import dtq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  dtq_in_if.sink     cmd,
  dtq_out_if.source  rsp
);

  // decoded command from the front queue to the table engine
  logic                 cmd_valid;
  dtq_op_t              cmd_op;
  logic [TIME_BITS-1:0] cmd_time;
  logic                 cmd_pop;

  // front: takes request items, decodes add or tick, holds up to two commands
  // so requests keep flowing while the table engine works or results stall
  dtq_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd_op),
    .cmd_time  (cmd_time),
    .cmd_pop   (cmd_pop)
  );

  // back: the sorted table of cells
  //   add  - every cell compares against the new expiry in parallel, cells
  //          at and after the insert point shift up by one, ties go first
  //   tick - pops the head one per cycle while due and results are taken, marks the last result
  // results leave through an output register that frees as it is taken
  dtq_back #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd_op),
    .cmd_time  (cmd_time),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule

// File: src/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// port-level checks of the timer queue results
// ----------------------------------------------------------------------------
module dtq_checker
  import dtq_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic                    result_kind,
  input logic [ID_FIELD_W-1:0]   timer_id,
  input logic [TIME_FIELD_W-1:0] expiry_out,
  input logic                    table_full,
  input logic                    last_in_run
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(timer_id) && $stable(expiry_out))
    else $error("result changed while stalled");

  // expired timers never carry the full flag
  a_expired_not_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (result_kind == KIND_EXPIRED) |-> !table_full)
    else $error("full flag on expired timer");

  // an add answer is a single result with zero expiry
  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (result_kind == KIND_ACK) |-> last_in_run && (expiry_out == '0))
    else $error("malformed add answer");

  // a rejected add carries identifier zero
  a_full_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && table_full |-> (timer_id == '0))
    else $error("rejected add with nonzero id");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind sorted_deadline_timer_queue_unit dtq_checker u_dtq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .result_kind (rsp.result_kind),
  .timer_id    (rsp.timer_id),
  .expiry_out  (rsp.expiry_out),
  .table_full  (rsp.table_full),
  .last_in_run (rsp.last_in_run)
);

// File: test/tb_sorted_deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_deadline_timer_queue_unit
// self-checking bench for the sorted one-shot timer table: a local copy of
// the table predicts every acknowledgment, full rejection and expiry, and a
// checker compares each result item in order while both channels idle at random
// ----------------------------------------------------------------------------
module tb_sorted_deadline_timer_queue_unit;
  import dtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH      = 16;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int DRAIN_CYCLES   = 12;

  // one expected result item
  typedef struct {
    dtq_kind_t               kind;
    logic [ID_FIELD_W-1:0]   id;
    logic [TIME_FIELD_W-1:0] expiry;
    logic                    full;
    logic                    last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtq_in_if  cmd_ch ();
  dtq_out_if rsp_ch ();

  sorted_deadline_timer_queue_unit #(
    .DEPTH     (TBL_DEPTH),
    .TIME_BITS (TIME_FIELD_W),
    .ID_BITS   (ID_FIELD_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // 2 ns period
  always #1ns clk = ~clk;

  // local copy of the sorted table, ascending by expiry
  logic [TIME_FIELD_W-1:0] shadow_expiry [TBL_DEPTH];
  logic [ID_FIELD_W-1:0]   shadow_id     [TBL_DEPTH];
  int                      shadow_count;
  logic [ID_FIELD_W-1:0]   id_counter;

  // results still owed by the block, oldest first
  timer_result_t timer_results_due[$];

  // knobs shared by the sender, the receiver and the tests
  int   send_idle_pct;
  int   rsp_stall_pct;
  logic rx_hold;
  event rx_hold_ev;
  logic [TIME_FIELD_W-1:0] now_ms;

  // bookkeeping
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned n_add_sent, n_tick_sent, id_wraps;
  int unsigned n_ack_seen, n_full_seen, n_expired_seen;

  // --------------------------------------------------------------------------
  // predictor: applies one accepted request to the shadow table and queues
  // the result items it causes
  // --------------------------------------------------------------------------
  function automatic void predict_timer_results(dtq_op_t op, logic [TIME_FIELD_W-1:0] tv);
    int            pos;
    int            due;
    timer_result_t r;
    if (op == OP_ADD) begin
      r.kind   = KIND_ACK;
      r.expiry = '0;
      r.last   = 1'b1;
      if (shadow_count >= TBL_DEPTH) begin
        // rejected: table and counter untouched
        r.id   = '0;
        r.full = 1'b1;
      end else begin
        // insert ahead of equal expiries
        pos = 0;
        while (pos < shadow_count && shadow_expiry[pos] < tv) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_expiry[i] = shadow_expiry[i-1];
          shadow_id[i]     = shadow_id[i-1];
        end
        shadow_expiry[pos] = tv;
        shadow_id[pos]     = id_counter;
        shadow_count++;
        r.id   = id_counter;
        r.full = 1'b0;
        id_counter = id_counter + 1'b1;
        if (id_counter == '0) id_wraps++;
      end
      timer_results_due = {timer_results_due, r};
    end else begin
      // pop every due head entry, capped per tick
      due = 0;
      while (due < shadow_count && due < MAX_RESULTS && shadow_expiry[due] <= tv) due++;
      for (int k = 0; k < due; k++) begin
        r.kind   = KIND_EXPIRED;
        r.id     = shadow_id[k];
        r.expiry = shadow_expiry[k];
        r.full   = 1'b0;
        r.last   = (k == due - 1);
        timer_results_due = {timer_results_due, r};
      end
      for (int i = 0; i + due < shadow_count; i++) begin
        shadow_expiry[i] = shadow_expiry[i+due];
        shadow_id[i]     = shadow_id[i+due];
      end
      shadow_count -= due;
    end
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // offer one item, with a random gap first; valid stays up after acceptance
  // so back-to-back items need no second assignment in the same step
  task automatic send_req(input dtq_op_t op, input logic [TIME_FIELD_W-1:0] tv);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.req_type   <= op;
    cmd_ch.time_value <= tv;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_timer_results(op, tv);
    if (op == OP_ADD) n_add_sent++;
    else n_tick_sent++;
  endtask

  // drop valid and wait for every owed result
  task automatic wait_all_results;
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (timer_results_due.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // long hold-off of the receiver, counted here
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // random back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= !rx_hold && (rsp_stall_pct == 0 || $urandom_range(99) >= rsp_stall_pct);
  end

  // compare each accepted result with the oldest expectation
  timer_result_t want;
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (timer_results_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t unexpected result: kind=%0d id=%0h expiry=%0h full=%0b last=%0b",
                   $realtime, rsp_ch.result_kind, rsp_ch.timer_id, rsp_ch.expiry_out,
                   rsp_ch.table_full, rsp_ch.last_in_run);
      end else begin
        want = timer_results_due.pop_front();
        if (rsp_ch.result_kind !== want.kind || rsp_ch.timer_id !== want.id ||
            rsp_ch.expiry_out !== want.expiry || rsp_ch.table_full !== want.full ||
            rsp_ch.last_in_run !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t mismatch: exp kind=%0d id=%0h expiry=%0h full=%0b last=%0b",
                     $realtime, want.kind, want.id, want.expiry, want.full, want.last);
            $display("    got kind=%0d id=%0h expiry=%0h full=%0b last=%0b",
                     rsp_ch.result_kind, rsp_ch.timer_id, rsp_ch.expiry_out,
                     rsp_ch.table_full, rsp_ch.last_in_run);
          end
        end
        if (want.kind == KIND_EXPIRED) n_expired_seen++;
        else if (want.full) n_full_seen++;
        else n_ack_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // empty ticks, extreme expiries, equal expiries and ordered expiry
  task automatic test_sorted_order;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    send_req(OP_TICK, '0);             // empty table, nothing due
    send_req(OP_ADD, 32'd100);
    send_req(OP_ADD, 32'd100);         // lands ahead of the first 100
    send_req(OP_ADD, '0);
    send_req(OP_ADD, '1);
    send_req(OP_TICK, 32'd99);         // only the zero expiry
    send_req(OP_TICK, 32'd100);        // both equal expiries, newer first
    send_req(OP_TICK, '1);             // the max expiry
    wait_all_results();
  endtask

  // fill to capacity, then adds get rejected without using an identifier
  task automatic test_full_table;
    for (int k = 0; k < TBL_DEPTH; k++) send_req(OP_ADD, $urandom_range(500, 0));
    send_req(OP_ADD, 32'd7);
    send_req(OP_TICK, '1);             // drains the whole table in one run
    wait_all_results();
  endtask

  // well-formed traffic around a moving clock, with some noise mixed in
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int add_pct, input int n_items);
    int                      sel;
    logic [TIME_FIELD_W-1:0] tv;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < add_pct) begin
        sel = $urandom_range(9);
        if (sel < 7) tv = now_ms + $urandom_range(40);
        else if (sel < 9) tv = $urandom();    // far off, piles up toward full
        else tv = now_ms;
        send_req(OP_ADD, tv);
      end else begin
        sel = $urandom_range(19);
        if (sel < 15) begin
          now_ms = now_ms + $urandom_range(20);
          tv = now_ms;
        end else if (sel < 17) tv = $urandom();
        else if (sel < 18) tv = '0;
        else tv = '1;
        send_req(OP_TICK, tv);
      end
    end
    wait_all_results();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    -> rx_hold_ev;
    for (int k = 0; k < 30; k++) begin
      if (k % 4 == 3) begin
        now_ms = now_ms + $urandom_range(10);
        send_req(OP_TICK, now_ms);
      end else begin
        send_req(OP_ADD, now_ms + $urandom_range(15));
      end
    end
    send_req(OP_TICK, '1);
    wait_all_results();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    cmd_ch.valid      = 1'b0;
    cmd_ch.req_type   = OP_ADD;
    cmd_ch.time_value = '0;
    rsp_ch.ready      = 1'b0;
    shadow_count      = 0;
    id_counter        = '0;
    send_idle_pct     = 0;
    rsp_stall_pct     = 0;
    now_ms            = 32'd1000;
    cycle_cnt         = 0;
    err_cnt           = 0;
    n_add_sent        = 0;
    n_tick_sent       = 0;
    id_wraps          = 0;
    n_ack_seen        = 0;
    n_full_seen       = 0;
    n_expired_seen    = 0;

    // hold reset, then release it
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sorted_order();
    test_full_table();
    test_random_traffic(0,  0,  55, 103);   // no idling
    test_random_traffic(65, 0,  70, 103);   // sender idle
    test_random_traffic(0,  65, 50, 103);   // receiver stalling
    test_random_traffic(34, 34, 65, 103);   // both
    test_backpressure();

    // tail: anything trailing the last result
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d adds and %0d ticks; saw %0d acks, %0d full rejections, %0d expiries",
             n_add_sent, n_tick_sent, n_ack_seen, n_full_seen, n_expired_seen);
    $display("identifier counter wrapped %0d time(s); %0d mismatches", id_wraps, err_cnt);
    if (err_cnt == 0 && timer_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
